>>> sv/lss_pkg.sv
// Shared types and constants of the LED scroll-effect sequencer.
// Used by lss_cfg_regs, lss_step_core and led_scroll_effect_sequencer.
package lss_pkg;

    // Panel geometry and frame ring size
    localparam logic [15:0] PANEL_COLUMNS = 16'd64;
    localparam logic [7:0]  PANEL_ROWS    = 8'd16;
    localparam logic [4:0]  FRAME_COUNT   = 5'd8;

    // Configuration register indexes
    localparam logic [2:0] REG_FAST_PERIOD  = 3'd0;
    localparam logic [2:0] REG_SLOW_PERIOD  = 3'd1;
    localparam logic [2:0] REG_RATE_CEILING = 3'd2;
    localparam logic [2:0] REG_LONG_HOLD    = 3'd3;
    localparam logic [2:0] REG_SHORT_HOLD   = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  FAST_PERIOD_RST  = 8'd2;
    localparam logic [7:0]  SLOW_PERIOD_RST  = 8'd20;
    localparam logic [7:0]  RATE_CEILING_RST = 8'hFF;
    localparam logic [15:0] LONG_HOLD_RST    = 16'd100;
    localparam logic [15:0] SHORT_HOLD_RST   = 16'd20;

    // Request types and effect modes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [7:0] MODE_WIPE  = 8'h00;
    localparam logic [7:0] MODE_BLINK = 8'h01;

    typedef struct packed {
        logic [7:0]  fast_period;
        logic [7:0]  slow_period;
        logic [7:0]  rate_ceiling;
        logic [15:0] long_hold;
        logic [15:0] short_hold;
    } lss_cfg_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] frame_rate;
        logic [7:0] frame_mode;
    } lss_item_t;

    typedef struct packed {
        logic [7:0] red_offset;
        logic [7:0] green_offset;
        logic [7:0] blue_offset;
        logic [7:0] vertical_shift;
        logic       blanked;
        logic       load_request;
        logic [3:0] next_frame;
    } lss_result_t;

endpackage

>>> sv/lss_cfg_regs.sv
// Configuration register file of the scroll-effect sequencer.
// Depends on lss_pkg for register indexes, reset values and lss_cfg_t.
module lss_cfg_regs
    import lss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output lss_cfg_t    cfg
);

    lss_cfg_t cfg_reg;
    lss_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FAST_PERIOD:  cfg_next.fast_period  = cfg_data[7:0];
                REG_SLOW_PERIOD:  cfg_next.slow_period  = cfg_data[7:0];
                REG_RATE_CEILING: cfg_next.rate_ceiling = cfg_data[7:0];
                REG_LONG_HOLD:    cfg_next.long_hold    = cfg_data;
                REG_SHORT_HOLD:   cfg_next.short_hold   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_period  <= FAST_PERIOD_RST;
            cfg_reg.slow_period  <= SLOW_PERIOD_RST;
            cfg_reg.rate_ceiling <= RATE_CEILING_RST;
            cfg_reg.long_hold    <= LONG_HOLD_RST;
            cfg_reg.short_hold   <= SHORT_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/lss_step_core.sv
// Effect state and single-pass update logic of the scroll-effect sequencer.
// Depends on lss_pkg; result is the display state after the current item.
module lss_step_core
    import lss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  lss_item_t   item,
    input  lss_cfg_t    cfg,
    output lss_result_t result
);

    // Wipe script steps
    localparam logic [2:0] W_FILL     = 3'd0;
    localparam logic [2:0] W_WIPE_R   = 3'd1;
    localparam logic [2:0] W_WIPE_G   = 3'd2;
    localparam logic [2:0] W_WIPE_B   = 3'd3;
    localparam logic [2:0] W_HOLD     = 3'd4;
    localparam logic [2:0] W_ROLL     = 3'd5;
    localparam logic [2:0] W_HOLD_END = 3'd6;

    // Blink script steps
    localparam logic [2:0] B_BLANK     = 3'd0;
    localparam logic [2:0] B_HOLD_DARK = 3'd1;
    localparam logic [2:0] B_SHOW      = 3'd2;
    localparam logic [2:0] B_HOLD_LIT  = 3'd3;
    localparam logic [2:0] B_HOLD      = 3'd4;
    localparam logic [2:0] B_ROLL_OUT  = 3'd5;
    localparam logic [2:0] B_ROLL_BACK = 3'd6;

    logic [7:0]  tick_reg, tick_next;
    logic [7:0]  rate_reg, rate_next;
    logic [7:0]  saved_reg, saved_next;
    logic [7:0]  mode_reg, mode_next;
    logic [2:0]  step_reg, step_next;
    logic [15:0] phase_reg, phase_next;
    logic [7:0]  roll_reg, roll_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic        blank_reg, blank_next;
    logic [3:0]  frame_reg, frame_next;
    logic        load_req;

    logic [7:0]  tick_inc;
    logic [15:0] phase_inc;
    logic [2:0]  step_inc;
    logic [7:0]  roll_inc;
    logic [7:0]  roll_dec;
    logic [4:0]  frame_inc;
    logic [3:0]  frame_wrap;
    logic        past_cols;
    logic        past_long;
    logic        past_short;
    logic        period_done;

    assign tick_inc    = tick_reg + 8'd1;
    assign phase_inc   = phase_reg + 16'd1;
    assign step_inc    = step_reg + 3'd1;
    assign roll_inc    = roll_reg + 8'd1;
    assign roll_dec    = roll_reg - 8'd1;
    assign frame_inc   = {1'b0, frame_reg} + 5'd1;
    assign frame_wrap  = (frame_inc >= FRAME_COUNT) ? 4'd0 : frame_inc[3:0];
    assign past_cols   = phase_inc > PANEL_COLUMNS;
    assign past_long   = phase_inc > cfg.long_hold;
    assign past_short  = phase_inc > cfg.short_hold;
    assign period_done = tick_inc > rate_reg;

    always_comb
    begin
        tick_next  = tick_reg;
        rate_next  = rate_reg;
        saved_next = saved_reg;
        mode_next  = mode_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        roll_next  = roll_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        blank_next = blank_reg;
        frame_next = frame_reg;
        load_req   = 1'b0;

        if (item.req_type == REQ_LOAD)
        begin
            rate_next  = (item.frame_rate > cfg.rate_ceiling) ? 8'd0 : item.frame_rate;
            mode_next  = item.frame_mode;
            step_next  = 3'd0;
            phase_next = 16'd0;
            roll_next  = 8'd0;
            red_next   = 8'd0;
            green_next = 8'd0;
            blue_next  = 8'd0;
        end
        else if (!period_done)
        begin
            tick_next = tick_inc;
        end
        else
        begin
            tick_next = 8'd0;
            if (mode_reg == MODE_WIPE)
            begin
                case (step_reg)
                    W_FILL:
                    begin
                        red_next   = red_reg + 8'd1;
                        green_next = green_reg + 8'd1;
                        blue_next  = blue_reg + 8'd1;
                        phase_next = phase_inc;
                        if (past_cols)
                        begin
                            phase_next = 16'd0;
                            step_next  = step_inc;
                            saved_next = rate_reg;
                            rate_next  = cfg.fast_period;
                        end
                    end
                    W_WIPE_R, W_WIPE_G, W_WIPE_B:
                    begin
                        if (step_reg == W_WIPE_R)
                            red_next = red_reg - 8'd1;
                        else if (step_reg == W_WIPE_G)
                            green_next = green_reg - 8'd1;
                        else
                            blue_next = blue_reg - 8'd1;
                        phase_next = past_cols ? 16'd0 : phase_inc;
                        step_next  = past_cols ? step_inc : step_reg;
                    end
                    W_HOLD:
                    begin
                        phase_next = phase_inc;
                        if (past_long)
                        begin
                            phase_next = 16'd0;
                            step_next  = step_inc;
                            saved_next = rate_reg;
                            rate_next  = cfg.slow_period;
                        end
                    end
                    W_ROLL:
                    begin
                        roll_next = roll_inc;
                        if (roll_inc >= PANEL_ROWS)
                        begin
                            step_next = W_HOLD_END;
                            roll_next = 8'd0;
                            rate_next = saved_reg;
                        end
                    end
                    W_HOLD_END:
                    begin
                        phase_next = past_long ? 16'd0 : phase_inc;
                        step_next  = past_long ? step_inc : step_reg;
                    end
                    default:
                    begin
                        frame_next = frame_wrap;
                        load_req   = 1'b1;
                    end
                endcase
            end
            else if (mode_reg == MODE_BLINK)
            begin
                case (step_reg)
                    B_BLANK:
                    begin
                        blank_next = 1'b1;
                        step_next  = B_HOLD_DARK;
                    end
                    B_HOLD_DARK, B_HOLD_LIT:
                    begin
                        phase_next = past_short ? 16'd0 : phase_inc;
                        step_next  = past_short ? step_inc : step_reg;
                    end
                    B_SHOW:
                    begin
                        blank_next = 1'b0;
                        step_next  = B_HOLD_LIT;
                    end
                    B_HOLD:
                    begin
                        phase_next = phase_inc;
                        if (past_long)
                        begin
                            phase_next = 16'd0;
                            step_next  = step_inc;
                            saved_next = rate_reg;
                            rate_next  = cfg.slow_period;
                        end
                    end
                    B_ROLL_OUT:
                    begin
                        red_next   = red_reg + 8'd1;
                        green_next = green_reg + 8'd1;
                        blue_next  = blue_reg + 8'd1;
                        roll_next  = roll_inc;
                        if (roll_inc >= PANEL_ROWS)
                        begin
                            step_next = B_ROLL_BACK;
                            rate_next = cfg.fast_period;
                        end
                    end
                    B_ROLL_BACK:
                    begin
                        red_next   = red_reg - 8'd1;
                        green_next = green_reg - 8'd1;
                        blue_next  = blue_reg - 8'd1;
                        roll_next  = roll_dec;
                        if (roll_dec == 8'd0)
                        begin
                            step_next = step_inc;
                            rate_next = saved_reg;
                        end
                    end
                    default:
                    begin
                        frame_next = frame_wrap;
                        load_req   = 1'b1;
                    end
                endcase
            end
            else
            begin
                // unknown effect: skip straight to the next frame
                frame_next = frame_wrap;
                load_req   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= 8'd0;
            rate_reg  <= 8'd0;
            saved_reg <= FAST_PERIOD_RST;
            mode_reg  <= MODE_WIPE;
            step_reg  <= 3'd0;
            phase_reg <= 16'd0;
            roll_reg  <= 8'd0;
            red_reg   <= 8'd0;
            green_reg <= 8'd0;
            blue_reg  <= 8'd0;
            blank_reg <= 1'b0;
            frame_reg <= 4'd0;
        end
        else if (step_en)
        begin
            tick_reg  <= tick_next;
            rate_reg  <= rate_next;
            saved_reg <= saved_next;
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            roll_reg  <= roll_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            blank_reg <= blank_next;
            frame_reg <= frame_next;
        end
    end

    assign result.red_offset     = red_next;
    assign result.green_offset   = green_next;
    assign result.blue_offset    = blue_next;
    assign result.vertical_shift = roll_next;
    assign result.blanked        = blank_next;
    assign result.load_request   = load_req;
    assign result.next_frame     = frame_next;

endmodule

>>> sv/led_scroll_effect_sequencer.sv
// Top level of the LED panel scroll-effect sequencer.
// Depends on lss_pkg, lss_cfg_regs and lss_step_core.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per timer tick
//   (req_type 0) or per loaded frame (req_type 1, with frame_rate and
//   frame_mode). Every input transaction yields exactly one output
//   transaction (out_valid/out_stall) with the plane offsets, vertical
//   shift, blank flag and a next-frame request with its frame index.
//   The item is held in an input register, updated against the effect state
//   in one pass, and the result is registered. Throughput is one item per
//   cycle while out_stall lets results drain; the state update loop in
//   lss_step_core closes in a single pass.
//   When out_stall is high with a result waiting, the input register fills
//   and in_stall rises; no item is lost or repeated.
//   Users must write configuration registers via cfg_write/cfg_index/cfg_data
//   only while the block is idle (unenforced); indexes above 4 are ignored.
//   Reset clears the pipeline and the effect state and loads the default
//   configuration; the block accepts items right after reset.
module led_scroll_effect_sequencer
    import lss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  frame_rate,
    input  logic [7:0]  frame_mode,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_offset,
    output logic [7:0]  green_offset,
    output logic [7:0]  blue_offset,
    output logic [7:0]  vertical_shift,
    output logic        blanked,
    output logic        load_request,
    output logic [3:0]  next_frame
);

    lss_cfg_t    cfg;
    lss_item_t   item_reg;
    lss_result_t step_result;
    lss_result_t result_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        step_en;

    lss_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lss_step_core u_step_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register frees up when empty or taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.req_type   <= req_type;
            item_reg.frame_rate <= frame_rate;
            item_reg.frame_mode <= frame_mode;
        end
        if (step_en)
            result_reg <= step_result;
    end

    assign out_valid      = out_valid_reg;
    assign red_offset     = result_reg.red_offset;
    assign green_offset   = result_reg.green_offset;
    assign blue_offset    = result_reg.blue_offset;
    assign vertical_shift = result_reg.vertical_shift;
    assign blanked        = result_reg.blanked;
    assign load_request   = result_reg.load_request;
    assign next_frame     = result_reg.next_frame;

    // Input side only backs up behind a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a stalled result");

    // A processed item shows up as a result on the next cycle
    a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    // A frame load never raises a next-frame request
    a_load_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item_reg.req_type == REQ_LOAD) |=> !result_reg.load_request)
        else $error("load item produced a next-frame request");

    // Requested frame index stays inside the frame ring
    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, result_reg.next_frame} < FRAME_COUNT))
        else $error("next frame index out of range");

endmodule

>>> verif/lss_effect_checker.sv
// Scoreboard for the LED scroll-effect sequencer: predicts and checks each result.
// Watches the register port and both channels of led_scroll_effect_sequencer.
// Depends on lss_pkg.
module lss_effect_checker
    import lss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  frame_rate,
    input  logic [7:0]  frame_mode,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red_offset,
    input  logic [7:0]  green_offset,
    input  logic [7:0]  blue_offset,
    input  logic [7:0]  vertical_shift,
    input  logic        blanked,
    input  logic        load_request,
    input  logic [3:0]  next_frame,
    output int          pending,
    output int          mismatches,
    output int          frame_requests
);
    timeunit 1ns;
    timeprecision 1ps;

    lss_cfg_t    cfg;
    logic [7:0]  tick_cnt;
    logic [7:0]  cur_rate;
    logic [7:0]  saved_rate;
    logic [7:0]  effect;
    logic [2:0]  step;
    logic [15:0] phase_cnt;
    logic [7:0]  rows;
    logic [7:0]  offs [3];
    logic        dark;
    logic [3:0]  frame_no;

    lss_result_t expected_settings [$];

    // Advance the hold counter; on passing the limit, clear it and move to the next step.
    function automatic logic bump_phase(logic [15:0] limit);
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt > limit)
        begin
            phase_cnt = '0;
            step = step + 3'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void shift_planes(logic up);
        foreach (offs[i])
            offs[i] = up ? offs[i] + 8'd1 : offs[i] - 8'd1;
    endfunction

    function automatic void request_frame();
        int n;
        n = int'(frame_no) + 1;
        if (n >= int'(FRAME_COUNT))
            n = 0;
        frame_no = 4'(n);
    endfunction

    task automatic advance_effect(input lss_item_t it, output lss_result_t r);
        logic req;
        req = 1'b0;
        if (it.req_type == REQ_LOAD)
        begin
            cur_rate  = (it.frame_rate > cfg.rate_ceiling) ? 8'd0 : it.frame_rate;
            effect    = it.frame_mode;
            step      = '0;
            phase_cnt = '0;
            rows      = '0;
            foreach (offs[i])
                offs[i] = '0;
        end
        else
        begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt > cur_rate)
            begin
                tick_cnt = '0;
                if (effect == MODE_WIPE)
                begin
                    case (step)
                        3'd0:
                        begin
                            shift_planes(1'b1);
                            if (bump_phase(PANEL_COLUMNS))
                            begin
                                saved_rate = cur_rate;
                                cur_rate   = cfg.fast_period;
                            end
                        end
                        3'd1, 3'd2, 3'd3:
                        begin
                            // wipe out one plane at a time
                            offs[2'(step - 3'd1)] = offs[2'(step - 3'd1)] - 8'd1;
                            void'(bump_phase(PANEL_COLUMNS));
                        end
                        3'd4:
                        begin
                            if (bump_phase(cfg.long_hold))
                            begin
                                saved_rate = cur_rate;
                                cur_rate   = cfg.slow_period;
                            end
                        end
                        3'd5:
                        begin
                            rows = rows + 8'd1;
                            if (rows >= PANEL_ROWS)
                            begin
                                step     = 3'd6;
                                rows     = '0;
                                cur_rate = saved_rate;
                            end
                        end
                        3'd6:
                            void'(bump_phase(cfg.long_hold));
                        default:
                        begin
                            request_frame();
                            req = 1'b1;
                        end
                    endcase
                end
                else if (effect == MODE_BLINK)
                begin
                    case (step)
                        3'd0:
                        begin
                            dark = 1'b1;
                            step = 3'd1;
                        end
                        3'd1, 3'd3:
                            void'(bump_phase(cfg.short_hold));
                        3'd2:
                        begin
                            dark = 1'b0;
                            step = 3'd3;
                        end
                        3'd4:
                        begin
                            if (bump_phase(cfg.long_hold))
                            begin
                                saved_rate = cur_rate;
                                cur_rate   = cfg.slow_period;
                            end
                        end
                        3'd5:
                        begin
                            shift_planes(1'b1);
                            rows = rows + 8'd1;
                            if (rows >= PANEL_ROWS)
                            begin
                                step     = 3'd6;
                                cur_rate = cfg.fast_period;
                            end
                        end
                        3'd6:
                        begin
                            // roll back down to the start
                            shift_planes(1'b0);
                            rows = rows - 8'd1;
                            if (rows == 8'd0)
                            begin
                                step     = 3'd7;
                                cur_rate = saved_rate;
                            end
                        end
                        default:
                        begin
                            request_frame();
                            req = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    request_frame();
                    req = 1'b1;
                end
            end
        end
        r.red_offset     = offs[0];
        r.green_offset   = offs[1];
        r.blue_offset    = offs[2];
        r.vertical_shift = rows;
        r.blanked        = dark;
        r.load_request   = req;
        r.next_frame     = frame_no;
    endtask

    function automatic int field_wrong(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lss_item_t   item;
        lss_result_t want;
        lss_result_t got;
        int          wrong;
        int          asked;
        if (!rst_n)
        begin
            cfg.fast_period  = FAST_PERIOD_RST;
            cfg.slow_period  = SLOW_PERIOD_RST;
            cfg.rate_ceiling = RATE_CEILING_RST;
            cfg.long_hold    = LONG_HOLD_RST;
            cfg.short_hold   = SHORT_HOLD_RST;
            tick_cnt   = '0;
            cur_rate   = '0;
            saved_rate = FAST_PERIOD_RST;
            effect     = '0;
            step       = '0;
            phase_cnt  = '0;
            rows       = '0;
            foreach (offs[i])
                offs[i] = '0;
            dark       = 1'b0;
            frame_no   = '0;
            expected_settings.delete();
            pending        <= 0;
            mismatches     <= 0;
            frame_requests <= 0;
        end
        else
        begin
            wrong = 0;
            asked = 0;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FAST_PERIOD:  cfg.fast_period  = cfg_data[7:0];
                    REG_SLOW_PERIOD:  cfg.slow_period  = cfg_data[7:0];
                    REG_RATE_CEILING: cfg.rate_ceiling = cfg_data[7:0];
                    REG_LONG_HOLD:    cfg.long_hold    = cfg_data;
                    REG_SHORT_HOLD:   cfg.short_hold   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                item = {req_type, frame_rate, frame_mode};
                advance_effect(item, want);
                expected_settings.push_back(want);
                asked = int'(want.load_request);
            end
            if (out_valid && !out_stall)
            begin
                got = {red_offset, green_offset, blue_offset, vertical_shift,
                       blanked, load_request, next_frame};
                if (expected_settings.size() == 0)
                begin
                    $error("result transaction arrived with nothing expected");
                    wrong = 1;
                end
                else
                begin
                    want = expected_settings.pop_front();
                    wrong += field_wrong("red_offset", want.red_offset, got.red_offset);
                    wrong += field_wrong("green_offset", want.green_offset, got.green_offset);
                    wrong += field_wrong("blue_offset", want.blue_offset, got.blue_offset);
                    wrong += field_wrong("vertical_shift", want.vertical_shift,
                                         got.vertical_shift);
                    wrong += field_wrong("blanked", 8'(want.blanked), 8'(got.blanked));
                    wrong += field_wrong("load_request", 8'(want.load_request),
                                         8'(got.load_request));
                    wrong += field_wrong("next_frame", 8'(want.next_frame),
                                         8'(got.next_frame));
                end
            end
            pending        <= expected_settings.size();
            mismatches     <= mismatches + wrong;
            frame_requests <= frame_requests + asked;
        end
    end

endmodule

>>> verif/led_scroll_effect_sequencer_tb.sv
// Testbench top for led_scroll_effect_sequencer: clock, reset, register writes,
// tick and frame-load stimulus with random idling, and the final verdict.
// Depends on lss_pkg, the sequencer RTL and lss_effect_checker.
module led_scroll_effect_sequencer_tb;
    import lss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETTINGS    = 7;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam int LIMIT_CYCLES    = 400000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_write  = 1'b0;
    logic [2:0]  cfg_index  = REG_FAST_PERIOD;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        req_type   = REQ_TICK;
    logic [7:0]  frame_rate = '0;
    logic [7:0]  frame_mode = MODE_WIPE;
    logic        out_stall  = 1'b1;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  red_offset;
    logic [7:0]  green_offset;
    logic [7:0]  blue_offset;
    logic [7:0]  vertical_shift;
    logic        blanked;
    logic        load_request;
    logic [3:0]  next_frame;

    int pending;
    int mismatches;
    int frame_requests;
    int items_sent  = 0;
    int cycle_count = 0;
    int hold_req    = 0;
    bit burst       = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    led_scroll_effect_sequencer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .frame_rate(frame_rate), .frame_mode(frame_mode),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_offset(red_offset), .green_offset(green_offset), .blue_offset(blue_offset),
        .vertical_shift(vertical_shift), .blanked(blanked),
        .load_request(load_request), .next_frame(next_frame)
    );

    lss_effect_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .frame_rate(frame_rate), .frame_mode(frame_mode),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_offset(red_offset), .green_offset(green_offset), .blue_offset(blue_offset),
        .vertical_shift(vertical_shift), .blanked(blanked),
        .load_request(load_request), .next_frame(next_frame),
        .pending(pending), .mismatches(mismatches), .frame_requests(frame_requests)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stall before each transaction, quiet stretches, and
    // a long hold-off whenever the stimulus asks for one.
    initial
    begin : drain_results
        int wait_cycles;
        int calm_left;
        int hold_done;
        calm_left = 0;
        hold_done = 0;
        forever
        begin
            if (hold_req != hold_done)
            begin
                hold_done   = hold_req;
                wait_cycles = HOLD_OFF_CYCLES;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                wait_cycles = 0;
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    calm_left = $urandom_range(20, 60);
                wait_cycles = $urandom_range(0, 13);
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Upper data bits beyond a register's width are random: they must be dropped.
    task automatic apply_config(input lss_cfg_t c);
        write_reg(REG_FAST_PERIOD, {8'($urandom), c.fast_period});
        write_reg(REG_SLOW_PERIOD, {8'($urandom), c.slow_period});
        write_reg(REG_RATE_CEILING, {8'($urandom), c.rate_ceiling});
        write_reg(REG_LONG_HOLD, c.long_hold);
        write_reg(REG_SHORT_HOLD, c.short_hold);
        write_reg(REG_SHORT_HOLD + 3'($urandom_range(1, 3)), 16'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input logic kind, input logic [7:0] rate, input logic [7:0] mode);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        frame_rate <= rate;
        frame_mode <= mode;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(REQ_TICK, 8'($urandom), 8'($urandom));
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        lss_cfg_t   plan [NUM_SETTINGS];
        int         budget [NUM_SETTINGS];
        int         stop_at;
        int         pick;
        int         n_ticks;
        logic [7:0] rate;
        logic [7:0] mode;

        // fast, slow, max, long hold, short hold
        plan[0] = {8'd0, 8'd0, 8'd200, 16'd0, 16'd0};
        plan[1] = {8'd0, 8'd0, 8'd255, 16'd3, 16'd2};
        plan[2] = {8'd1, 8'd2, 8'd255, 16'd1, 16'd5};
        plan[3] = {8'd0, 8'd0, 8'd0, 16'd0, 16'd0};
        plan[4] = {8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF};
        plan[5] = {8'd0, 8'd1, 8'd100, 16'd2, 16'd0};
        plan[6] = {8'd2, 8'd20, 8'd255, 16'd100, 16'd20};
        budget  = '{0, 270, 260, 260, 240, 270, 200};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rate capping at and past the limit, every effect, frame wrap.
        apply_config(plan[0]);
        send_item(REQ_LOAD, 8'hFF, MODE_WIPE);
        send_ticks(3);
        send_item(REQ_LOAD, 8'd200, MODE_BLINK);
        send_ticks(2);
        send_item(REQ_LOAD, 8'd201, MODE_BLINK);
        send_ticks(4);
        send_item(REQ_LOAD, 8'd0, 8'hFF);
        send_ticks(9);
        send_item(REQ_LOAD, 8'd1, MODE_BLINK + 8'd1);
        send_ticks(2);
        settle();

        for (int p = 1; p < NUM_SETTINGS; p++)
        begin
            apply_config(plan[p]);
            if (p == 2)
            begin
                // back-pressure: receiver holds off while transactions keep coming
                hold_req++;
                burst = 1'b1;
                send_ticks(40);
            end
            stop_at = items_sent + budget[p];
            while (items_sent < stop_at)
            begin
                burst = ($urandom_range(0, 3) == 0);
                pick  = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    rate = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 2))
                                                      : 8'($urandom);
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                    begin
                        mode    = MODE_WIPE;
                        n_ticks = $urandom_range(60, 360);
                    end
                    else if (pick < 80)
                    begin
                        mode    = MODE_BLINK;
                        n_ticks = $urandom_range(20, 120);
                    end
                    else
                    begin
                        mode    = 8'($urandom_range(2, 255));
                        n_ticks = $urandom_range(1, 20);
                    end
                    // trim the last script so each setting stays near its budget
                    if (n_ticks > stop_at - items_sent - 1)
                        n_ticks = stop_at - items_sent - 1;
                    send_item(REQ_LOAD, rate, mode);
                    send_ticks(n_ticks);
                end
                else
                begin
                    // noise: loads and ticks in any order with any payload
                    repeat ($urandom_range(1, 15))
                        send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
                end
            end
            burst = 1'b0;
            settle();
        end

        repeat (8) @(posedge clk);
        $display("Ran %0d transactions over %0d register settings; %0d next-frame requests seen",
                 items_sent, NUM_SETTINGS, frame_requests);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
